>>> sv/assert_macros.svh
// Assertion macros shared by the route table modules.
// Included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> sv/dvrt_pkg.sv
// Types and constants for the distance-vector route table.
// No dependencies.
package dvrt_pkg;
    localparam logic [7:0] DASH_NAME  = 8'd45;
    localparam logic [7:0] RESET_COST = 8'd20;

    typedef enum logic [2:0] {
        FUNC_LOAD  = 3'd0,
        FUNC_HELLO = 3'd1,
        FUNC_ROUTE = 3'd2,
        FUNC_TICK  = 3'd3,
        FUNC_READ  = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        CFG_HOME    = 2'd0,
        CFG_COUNT   = 2'd1,
        CFG_INF     = 2'd2,
        CFG_TIMEOUT = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HELLO,
        ST_HOME,
        ST_RELAX,
        ST_REVIVE,
        ST_TIMEOUT,
        ST_DONE
    } state_t;

    // search unit request and response
    typedef struct packed {
        logic       start;
        logic [7:0] name_a;
        logic [7:0] name_b;
    } search_req_t;

    typedef struct packed {
        logic busy;
        logic found_a;
        logic found_b;
    } search_rsp_t;
endpackage

>>> sv/dvrt_search.sv
// Sequential name search: one slot compared per cycle against two names.
// Uses dvrt_pkg.
module dvrt_search #(
    parameter int IDX_W = 5,
    parameter int CNT_W = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dvrt_pkg::search_req_t req,
    input  logic [CNT_W-1:0]      limit,
    input  logic [7:0]            slot_name_rd,
    output logic [IDX_W-1:0]      scan_idx,
    output dvrt_pkg::search_rsp_t rsp,
    output logic [IDX_W-1:0]      idx_a,
    output logic [IDX_W-1:0]      idx_b
);
    import dvrt_pkg::*;

    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             busy_reg, busy_next;
    logic             fa_reg, fa_next, fb_reg, fb_next;
    logic [IDX_W-1:0] ia_reg, ia_next, ib_reg, ib_next;
    logic [7:0]       na_reg, nb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            busy_reg <= 1'b0;
            fa_reg   <= 1'b0;
            fb_reg   <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            busy_reg <= busy_next;
            fa_reg   <= fa_next;
            fb_reg   <= fb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ia_reg <= ia_next;
        ib_reg <= ib_next;
        if (req.start)
        begin
            na_reg <= req.name_a;
            nb_reg <= req.name_b;
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        busy_next = busy_reg;
        fa_next   = fa_reg;
        fb_next   = fb_reg;
        ia_next   = ia_reg;
        ib_next   = ib_reg;
        if (req.start)
        begin
            pos_next  = '0;
            busy_next = 1'b1;
            fa_next   = 1'b0;
            fb_next   = 1'b0;
        end
        else if (busy_reg)
        begin
            if (pos_reg >= limit)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (!fa_reg && slot_name_rd == na_reg)
                begin
                    fa_next = 1'b1;
                    ia_next = pos_reg[IDX_W-1:0];
                end
                if (!fb_reg && slot_name_rd == nb_reg)
                begin
                    fb_next = 1'b1;
                    ib_next = pos_reg[IDX_W-1:0];
                end
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    assign scan_idx    = pos_reg[IDX_W-1:0];
    assign rsp.busy    = busy_reg;
    assign rsp.found_a = fa_reg;
    assign rsp.found_b = fb_reg;
    assign idx_a       = ia_reg;
    assign idx_b       = ib_reg;

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_pos_bound, clk, rst_n, busy_reg, pos_reg <= limit)
    `ASSERT_NEXT(a_start_busy, clk, rst_n, req.start, busy_reg && !fa_reg && !fb_reg)
    `ASSERT_NEXT(a_found_sticky, clk, rst_n, busy_reg && fa_reg && !req.start, fa_reg)
endmodule

>>> sv/distance_vector_route_table.sv
// Distance-vector route table. Top level: sequencer, slot storage, sweep.
// Uses dvrt_pkg, dvrt_search, assert_macros.svh.
//
// Usage: one input transaction on in_valid/in_ready (func and operands), one
// result transaction on out_valid/out_ready per input. Configuration uses a
// plain write port (cfg_we, cfg_index, cfg_data) taken only while idle; the
// user must keep to this, since the block itself does not enforce it.
// Load, read and unused codes go straight to done; hello and route run the
// name search, then a hello, home or relax state; tick sweeps the slots in
// revive and then in timeout. in_ready returns in the same cycle as out_valid.
// The name search and the sweep step one slot per cycle.
// in_ready is low from acceptance until the result enters the output
// register. One result may wait there while the next transaction runs; if
// the receiver still stalls when that one finishes, the block holds in done.
// Reset: all slots return to name 45, cost 20, alive set; time is zero;
// registers take their reset values. No clearing pass is needed.
module distance_vector_route_table #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] func,
    input  logic [4:0] entry_index,
    input  logic [7:0] target_name,
    input  logic [7:0] source_name,
    input  logic [7:0] next_hop_name,
    input  logic [7:0] cost,
    input  logic       adjacent_flag,
    input  logic [7:0] ticks_elapsed,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       table_changed,
    output logic       name_found,
    output logic [7:0] entry_name,
    output logic [7:0] entry_cost,
    output logic [7:0] entry_next_hop,
    output logic       entry_adjacent,
    output logic       entry_connected,
    output logic       entry_alive
);
    import dvrt_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [7:0]  home_reg, inf_reg, tmo_reg;
    logic [5:0]  count_reg;
    logic [31:0] now_reg;

    logic [7:0]  name_reg   [MAX_ENTRIES];
    logic [7:0]  cost_reg   [MAX_ENTRIES];
    logic [7:0]  icost_reg  [MAX_ENTRIES];
    logic [7:0]  hop_reg    [MAX_ENTRIES];
    logic [31:0] heard_reg  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] adj_reg, conn_reg, alive_reg;

    state_t state_reg, state_next;
    func_t  func_reg;
    logic [4:0] eidx_reg;
    logic [7:0] nname_reg, sname_reg, hop_in_reg, cost_in_reg;
    logic       adjf_reg;
    logic [CNT_W-1:0] sweep_reg, sweep_next;
    logic       changed_reg, changed_next;
    logic       out_valid_reg;
    logic       found_reg;
    logic [7:0] o_name_reg, o_cost_reg, o_hop_reg;
    logic       o_adj_reg, o_conn_reg, o_alive_reg;

    logic [CNT_W-1:0] active;
    assign active = (int'(count_reg) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                     : CNT_W'(count_reg);

    search_req_t      sreq;
    search_rsp_t      srsp;
    logic [IDX_W-1:0] scan_idx, ia, ib;

    dvrt_search #(.IDX_W(IDX_W), .CNT_W(CNT_W)) u_search (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (sreq),
        .limit        (active),
        .slot_name_rd (name_reg[scan_idx]),
        .scan_idx     (scan_idx),
        .rsp          (srsp),
        .idx_a        (ia),
        .idx_b        (ib)
    );

    logic accept;
    logic done_go;
    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign done_go  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        sreq.start  = 1'b0;
        sreq.name_a = sname_reg;
        sreq.name_b = nname_reg;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func_t'(func))
                        FUNC_HELLO, FUNC_ROUTE:
                        begin
                            state_next  = ST_SEARCH;
                            sreq.start  = 1'b1;
                            sreq.name_a = source_name;
                            sreq.name_b = target_name;
                        end
                        FUNC_TICK: state_next = ST_REVIVE;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (!srsp.busy)
                begin
                    if (func_reg == FUNC_HELLO)
                        state_next = ST_HELLO;
                    else if (nname_reg == home_reg)
                        state_next = ST_HOME;
                    else
                        state_next = ST_RELAX;
                end
            end
            ST_HELLO, ST_HOME, ST_RELAX: state_next = ST_DONE;
            ST_REVIVE:
            begin
                if (sweep_reg >= active)
                    state_next = ST_TIMEOUT;
            end
            ST_TIMEOUT:
            begin
                if (sweep_reg >= active)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (done_go)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= func_t'(func);
            eidx_reg    <= entry_index;
            nname_reg   <= target_name;
            sname_reg   <= source_name;
            hop_in_reg  <= next_hop_name;
            cost_in_reg <= cost;
            adjf_reg    <= adjacent_flag;
        end
    end

    // shared adder/compare for relaxation
    logic [8:0] rsum;
    logic [7:0] rsat;
    logic       in_range;
    assign rsum     = {1'b0, cost_reg[ia]} + {1'b0, cost_in_reg};
    assign rsat     = (rsum > {1'b0, inf_reg}) ? inf_reg : rsum[7:0];
    assign in_range = 32'(eidx_reg) < 32'(MAX_ENTRIES);

    logic       relax_take;
    logic [8:0] rsum2;
    logic [7:0] rsat2, relax_cost, relax_hop;
    assign relax_take = hop_in_reg != home_reg && {1'b0, cost_reg[ib]} > rsum;
    assign rsum2      = {1'b0, rsat} + {1'b0, cost_in_reg};
    assign rsat2      = (rsum2 > {1'b0, inf_reg}) ? inf_reg : rsum2[7:0];

    always_comb
    begin
        relax_cost = cost_reg[ib];
        relax_hop  = hop_reg[ib];
        if (relax_take)
        begin
            relax_hop  = sname_reg;
            // a non-adjacent destination that is also the sender adds the cost twice
            relax_cost = (!adj_reg[ib] && ia == ib) ? rsat2 : rsat;
        end
        else if (!adj_reg[ib])
            relax_cost = rsat;
    end

    logic [IDX_W-1:0] widx;
    logic [IDX_W-1:0] sidx;
    logic [31:0]      age;
    assign widx = IDX_W'(eidx_reg);
    assign sidx = sweep_reg[IDX_W-1:0];
    assign age  = now_reg - heard_reg[sidx];

    always_comb
    begin
        sweep_next   = sweep_reg;
        changed_next = changed_reg;
        if (state_reg == ST_IDLE)
        begin
            sweep_next   = '0;
            changed_next = 1'b0;
        end
        else if (state_reg == ST_HOME)
        begin
            if (srsp.found_a && cost_reg[ia] != icost_reg[ia])
                changed_next = 1'b1;
        end
        else if (state_reg == ST_RELAX)
        begin
            if (srsp.found_a && srsp.found_b
                && (relax_cost != cost_reg[ib] || relax_hop != hop_reg[ib]))
                changed_next = 1'b1;
        end
        else if ((state_reg == ST_REVIVE || state_reg == ST_TIMEOUT))
        begin
            if (sweep_reg >= active)
                sweep_next = '0;
            else
                sweep_next = sweep_reg + 1'b1;
            if (state_reg == ST_TIMEOUT && sweep_reg < active && !age[31]
                && age >= 32'(tmo_reg) && adj_reg[sidx] && alive_reg[sidx]
                && cost_reg[sidx] != inf_reg)
                changed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_reg      <= DASH_NAME;
            count_reg     <= '0;
            inf_reg       <= RESET_COST;
            tmo_reg       <= 8'd16;
            now_reg       <= '0;
            adj_reg       <= '0;
            conn_reg      <= '0;
            alive_reg     <= '1;
            sweep_reg     <= '0;
            changed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                name_reg[i]  <= DASH_NAME;
                cost_reg[i]  <= RESET_COST;
                icost_reg[i] <= RESET_COST;
                hop_reg[i]   <= DASH_NAME;
                heard_reg[i] <= '0;
            end
        end
        else
        begin
            sweep_reg   <= sweep_next;
            changed_reg <= changed_next;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_HOME:    home_reg  <= cfg_data;
                    CFG_COUNT:   count_reg <= cfg_data[5:0];
                    CFG_INF:     inf_reg   <= cfg_data;
                    CFG_TIMEOUT: tmo_reg   <= cfg_data;
                    default:     home_reg  <= home_reg;
                endcase
            end
            if (done_go)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_HELLO:
                begin
                    if (srsp.found_a)
                    begin
                        heard_reg[ia] <= now_reg;
                        alive_reg[ia] <= 1'b1;
                    end
                end
                ST_HOME:
                begin
                    if (srsp.found_a)
                    begin
                        alive_reg[ia] <= 1'b1;
                        cost_reg[ia]  <= icost_reg[ia];
                    end
                end
                ST_RELAX:
                begin
                    if (srsp.found_a && srsp.found_b)
                    begin
                        cost_reg[ib] <= relax_cost;
                        hop_reg[ib]  <= relax_hop;
                        if (relax_take)
                            conn_reg[ib] <= 1'b1;
                    end
                end
                ST_REVIVE:
                begin
                    if (sweep_reg < active && cost_reg[sidx] < inf_reg
                        && !alive_reg[sidx])
                    begin
                        alive_reg[sidx] <= 1'b1;
                        heard_reg[sidx] <= now_reg + 32'(tmo_reg >> 1);
                    end
                end
                ST_TIMEOUT:
                begin
                    if (sweep_reg < active && !age[31] && age >= 32'(tmo_reg)
                        && adj_reg[sidx] && alive_reg[sidx])
                    begin
                        alive_reg[sidx] <= 1'b0;
                        cost_reg[sidx]  <= inf_reg;
                    end
                end
                ST_DONE:
                begin
                    if (done_go)
                    begin
                        case (func_reg)
                            FUNC_LOAD:
                            begin
                                found_reg <= in_range;
                                if (in_range)
                                begin
                                    name_reg[widx] <= nname_reg;
                                    cost_reg[widx] <= cost_in_reg;
                                    if (adjf_reg)
                                    begin
                                        adj_reg[widx]   <= 1'b1;
                                        conn_reg[widx]  <= 1'b1;
                                        icost_reg[widx] <= cost_in_reg;
                                        hop_reg[widx]   <= home_reg;
                                    end
                                end
                            end
                            FUNC_HELLO: found_reg <= srsp.found_a;
                            FUNC_ROUTE:
                                found_reg <= srsp.found_a
                                    && (nname_reg == home_reg || srsp.found_b);
                            FUNC_TICK:  found_reg <= 1'b1;
                            FUNC_READ:  found_reg <= in_range;
                            default:    found_reg <= 1'b0;
                        endcase
                    end
                end
                default:
                begin
                    if (accept && func_t'(func) == FUNC_TICK)
                        now_reg <= now_reg + 32'(ticks_elapsed);
                end
            endcase
        end
    end

    // load change flag and read data captured at done
    logic load_chg;
    assign load_chg = in_range && (name_reg[widx] != nname_reg
        || cost_reg[widx] != cost_in_reg
        || (adjf_reg && hop_reg[widx] != home_reg));

    always_ff @(posedge clk)
    begin
        if (done_go)
        begin
            o_name_reg  <= '0;
            o_cost_reg  <= '0;
            o_hop_reg   <= '0;
            o_adj_reg   <= 1'b0;
            o_conn_reg  <= 1'b0;
            o_alive_reg <= 1'b0;
            if (func_reg == FUNC_READ && in_range)
            begin
                o_name_reg  <= name_reg[widx];
                o_cost_reg  <= cost_reg[widx];
                o_hop_reg   <= hop_reg[widx];
                o_adj_reg   <= adj_reg[widx];
                o_conn_reg  <= conn_reg[widx];
                o_alive_reg <= alive_reg[widx];
            end
        end
    end

    logic chg_out_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chg_out_reg <= 1'b0;
        else if (done_go)
            chg_out_reg <= (func_reg == FUNC_LOAD) ? load_chg
                         : (func_reg == FUNC_READ) ? 1'b0 : changed_reg;
    end

    assign out_valid       = out_valid_reg;
    assign table_changed   = chg_out_reg;
    assign name_found      = found_reg;
    assign entry_name      = o_name_reg;
    assign entry_cost      = o_cost_reg;
    assign entry_next_hop  = o_hop_reg;
    assign entry_adjacent  = o_adj_reg;
    assign entry_connected = o_conn_reg;
    assign entry_alive     = o_alive_reg;

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_busy_not_ready, clk, rst_n, state_reg != ST_IDLE, !in_ready)
    `ASSERT_NEXT(a_done_valid, clk, rst_n, done_go, out_valid_reg)
    `ASSERT_NEXT(a_valid_held, clk, rst_n, out_valid_reg && !out_ready, out_valid_reg)
endmodule

>>> bench/testbench.sv
// Self-checking testbench for distance_vector_route_table.
// Drives load, hello, route, tick and read transactions, predicts each result.
// Depends on dvrt_pkg and the route table RTL.
`timescale 1ns / 1ps

module testbench;
    import dvrt_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] func = '0;
    logic [4:0] entry_index = '0;
    logic [7:0] target_name = '0;
    logic [7:0] source_name = '0;
    logic [7:0] next_hop_name = '0;
    logic [7:0] cost = '0;
    logic       adjacent_flag = 1'b0;
    logic [7:0] ticks_elapsed = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       table_changed, name_found, entry_adjacent, entry_connected, entry_alive;
    logic [7:0] entry_name, entry_cost, entry_next_hop;

    distance_vector_route_table dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    typedef struct packed {
        logic [2:0] fn;
        logic [4:0] idx;
        logic [7:0] nname;
        logic [7:0] sname;
        logic [7:0] hop;
        logic [7:0] cst;
        logic       adj;
        logic [7:0] ticks;
    } route_req_t;

    typedef struct packed {
        logic       changed;
        logic       found;
        logic [7:0] name;
        logic [7:0] cst;
        logic [7:0] hop;
        logic       adj;
        logic       conn;
        logic       alive;
    } route_rsp_t;

    typedef struct {
        route_req_t req;
        logic       typed;
        route_rsp_t rsp;
    } stim_row_t;

    // predictor state
    logic [7:0]  home_q, inf_q, tmo_q;
    logic [5:0]  count_q;
    logic [7:0]  tbl_name [32];
    logic [7:0]  tbl_cost [32];
    logic [7:0]  tbl_init [32];
    logic [7:0]  tbl_hop [32];
    logic        tbl_adj [32];
    logic        tbl_conn [32];
    logic        tbl_alive [32];
    logic [31:0] tbl_heard [32];
    logic [31:0] now_q;

    route_rsp_t  expected_q[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;
    bit          long_stall = 1'b0;
    bit          done = 1'b0;

    function automatic int active_n();
        return (count_q > 32) ? 32 : int'(count_q);
    endfunction

    function automatic int lookup(logic [7:0] nm);
        for (int i = 0; i < active_n(); i++)
            if (tbl_name[i] == nm)
                return i;
        return -1;
    endfunction

    function automatic logic [7:0] cap_sum(logic [7:0] a, logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, inf_q}) ? inf_q : s[7:0];
    endfunction

    task automatic table_reset();
        home_q = 8'd45; count_q = '0; inf_q = 8'd20; tmo_q = 8'd16; now_q = '0;
        for (int i = 0; i < 32; i++)
        begin
            tbl_name[i] = DASH_NAME; tbl_cost[i] = RESET_COST;
            tbl_init[i] = RESET_COST; tbl_hop[i] = DASH_NAME;
            tbl_adj[i] = 1'b0; tbl_conn[i] = 1'b0; tbl_alive[i] = 1'b1;
            tbl_heard[i] = '0;
        end
    endtask

    function automatic route_rsp_t route_predict(route_req_t r);
        route_rsp_t o;
        int s, d;
        logic [7:0] oc, oh;
        logic [8:0] raw;
        logic [31:0] age;
        o = '0;
        case (r.fn)
            FUNC_LOAD:
            begin
                o.found = 1'b1;
                if (tbl_name[r.idx] != r.nname || tbl_cost[r.idx] != r.cst)
                    o.changed = 1'b1;
                tbl_name[r.idx] = r.nname;
                tbl_cost[r.idx] = r.cst;
                if (r.adj)
                begin
                    if (tbl_hop[r.idx] != home_q)
                        o.changed = 1'b1;
                    tbl_adj[r.idx] = 1'b1; tbl_conn[r.idx] = 1'b1;
                    tbl_init[r.idx] = r.cst; tbl_hop[r.idx] = home_q;
                end
            end
            FUNC_HELLO:
            begin
                s = lookup(r.sname);
                if (s >= 0)
                begin
                    o.found = 1'b1;
                    tbl_heard[s] = now_q;
                    tbl_alive[s] = 1'b1;
                end
            end
            FUNC_ROUTE:
            begin
                s = lookup(r.sname);
                if (r.nname == home_q)
                begin
                    if (s >= 0)
                    begin
                        o.found = 1'b1;
                        o.changed = tbl_cost[s] != tbl_init[s];
                        tbl_alive[s] = 1'b1;
                        tbl_cost[s] = tbl_init[s];
                    end
                end
                else
                begin
                    d = lookup(r.nname);
                    if (s >= 0 && d >= 0)
                    begin
                        oc = tbl_cost[d]; oh = tbl_hop[d];
                        o.found = 1'b1;
                        raw = {1'b0, tbl_cost[s]} + {1'b0, r.cst};
                        if (r.hop != home_q && {1'b0, tbl_cost[d]} > raw)
                        begin
                            tbl_cost[d] = cap_sum(tbl_cost[s], r.cst);
                            tbl_conn[d] = 1'b1;
                            tbl_hop[d] = r.sname;
                        end
                        if (!tbl_adj[d])
                            tbl_cost[d] = cap_sum(tbl_cost[s], r.cst);
                        o.changed = (tbl_cost[d] != oc) || (tbl_hop[d] != oh);
                    end
                end
            end
            FUNC_TICK:
            begin
                o.found = 1'b1;
                now_q += r.ticks;
                for (int i = 0; i < active_n(); i++)
                    if (tbl_cost[i] < inf_q && !tbl_alive[i])
                    begin
                        tbl_alive[i] = 1'b1;
                        tbl_heard[i] = now_q + (tmo_q >> 1);
                    end
                for (int i = 0; i < active_n(); i++)
                begin
                    age = now_q - tbl_heard[i];
                    if (!age[31] && age >= tmo_q && tbl_adj[i] && tbl_alive[i])
                    begin
                        tbl_alive[i] = 1'b0;
                        if (tbl_cost[i] != inf_q)
                            o.changed = 1'b1;
                        tbl_cost[i] = inf_q;
                    end
                end
            end
            FUNC_READ:
            begin
                o.found = 1'b1;
                o.name = tbl_name[r.idx]; o.cst = tbl_cost[r.idx];
                o.hop = tbl_hop[r.idx]; o.adj = tbl_adj[r.idx];
                o.conn = tbl_conn[r.idx]; o.alive = tbl_alive[r.idx];
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic reg_write(cfg_idx_t ix, logic [7:0] v);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= ix; cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (ix)
            CFG_HOME:    home_q = v;
            CFG_COUNT:   count_q = v[5:0];
            CFG_INF:     inf_q = v;
            CFG_TIMEOUT: tmo_q = v;
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // typed rows carry a result readable at a glance, held to the predictor
    task automatic send(route_req_t r, logic typed = 1'b0, route_rsp_t want = '0);
        route_rsp_t p;
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        p = route_predict(r);
        if (typed && p != want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with predictor: %h vs %h", want, p);
        end
        expected_q.push_back(p);
        func <= r.fn; entry_index <= r.idx; target_name <= r.nname;
        source_name <= r.sname; next_hop_name <= r.hop; cost <= r.cst;
        adjacent_flag <= r.adj; ticks_elapsed <= r.ticks;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic route_req_t rnd_req(int names);
        route_req_t r;
        logic [63:0] bits_q;
        bits_q = {$urandom, $urandom};
        r = bits_q[$bits(route_req_t)-1:0];
        r.fn = 3'($urandom_range(0, 5));
        if ($urandom_range(0, 19) == 0)
            r.fn = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 9) != 0)
        begin
            r.nname = 8'(100 + $urandom_range(0, names));
            r.sname = 8'(100 + $urandom_range(0, names));
        end
        if ($urandom_range(0, 3) != 0)
            r.cst = 8'($urandom_range(0, 12));
        if (r.fn == FUNC_TICK && $urandom_range(0, 3) != 0)
            r.ticks = 8'($urandom_range(0, 6));
        if ($urandom_range(0, 3) == 0)
            r.hop = home_q;
        if (r.fn > FUNC_READ && r.fn != 3'(5))
            r.fn = (r.fn == 3'd6) ? FUNC_ROUTE : r.fn;
        return r;
    endfunction

    stim_row_t rows[$];

    function automatic stim_row_t mk(func_t f, int ix, int nn, int sn, int hp, int c,
                                     bit a, int t, bit typed, route_rsp_t w);
        stim_row_t s;
        s.req = '{f, 5'(ix), 8'(nn), 8'(sn), 8'(hp), 8'(c), a, 8'(t)};
        s.typed = typed;
        s.rsp = w;
        return s;
    endfunction

    initial
    begin
        route_req_t r;
        int names;
        table_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        rows.push_back(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 1,
                          '{0, 1, 8'd45, 8'd20, 8'd45, 0, 0, 1}));
        rows.push_back(mk(FUNC_READ, 31, 0, 0, 0, 0, 0, 0, 1,
                          '{0, 1, 8'd45, 8'd20, 8'd45, 0, 0, 1}));
        rows.push_back(mk(FUNC_HELLO, 0, 0, 7, 0, 0, 0, 0, 1, '0));
        rows.push_back(mk(FUNC_ROUTE, 0, 9, 7, 0, 3, 0, 0, 1, '0));
        rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 255, 1, '{0, 1, 0, 0, 0, 0, 0, 0}));
        rows.push_back(mk(func_t'(3'd5), 0, 0, 0, 0, 0, 0, 0, 1, '0));
        rows.push_back(mk(func_t'(3'd7), 31, 255, 255, 255, 255, 1, 255, 1, '0));
        foreach (rows[i])
            send(rows[i].req, rows[i].typed, rows[i].rsp);
        rows.delete();
        drain();

        reg_write(CFG_COUNT, 8'd4);
        reg_write(CFG_HOME, 8'd200);
        rows.push_back(mk(FUNC_LOAD, 0, 100, 0, 0, 1, 1, 0, 0, '0));
        rows.push_back(mk(FUNC_LOAD, 1, 101, 0, 0, 2, 1, 0, 0, '0));
        rows.push_back(mk(FUNC_LOAD, 2, 102, 0, 0, 255, 0, 0, 0, '0));
        rows.push_back(mk(FUNC_LOAD, 3, 103, 0, 0, 0, 0, 0, 0, '0));
        rows.push_back(mk(FUNC_HELLO, 0, 0, 100, 0, 0, 0, 0, 0, '0));
        rows.push_back(mk(FUNC_ROUTE, 0, 102, 100, 5, 3, 0, 0, 0, '0));
        rows.push_back(mk(FUNC_ROUTE, 0, 102, 101, 200, 0, 0, 0, 0, '0));
        rows.push_back(mk(FUNC_ROUTE, 0, 103, 101, 5, 255, 0, 0, 0, '0));
        rows.push_back(mk(FUNC_ROUTE, 0, 200, 101, 0, 0, 0, 0, 0, '0));
        rows.push_back(mk(FUNC_ROUTE, 0, 200, 99, 0, 0, 0, 0, 0, '0));
        rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, '0));
        rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 20, 0, '0));
        rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 9, 0, '0));
        rows.push_back(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0, '0));
        rows.push_back(mk(FUNC_READ, 2, 0, 0, 0, 0, 0, 0, 0, '0));
        foreach (rows[i])
            send(rows[i].req, rows[i].typed, rows[i].rsp);
        drain();

        // random phases over several register settings, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin reg_write(CFG_INF, 8'd255); reg_write(CFG_TIMEOUT, 8'd2); end
                1: begin reg_write(CFG_INF, 8'd1); reg_write(CFG_TIMEOUT, 8'd255);
                         reg_write(CFG_COUNT, 8'd32); reg_write(CFG_HOME, 8'd0); end
                2: begin reg_write(CFG_COUNT, 8'd0); reg_write(CFG_HOME, 8'd255); end
                3: begin reg_write(CFG_COUNT, 8'd63); reg_write(CFG_INF, 8'd20);
                         reg_write(CFG_TIMEOUT, 8'd6); end
                4: begin reg_write(CFG_COUNT, 8'd8); reg_write(CFG_INF, 8'd30); end
                default: begin reg_write(CFG_COUNT, 8'd12); reg_write(CFG_HOME, 8'd45);
                               reg_write(CFG_TIMEOUT, 8'd16); end
            endcase
            names = (active_n() > 0) ? active_n() + 1 : 4;
            if (ph == 3)
                long_stall = 1'b1;
            for (int k = 0; k < 105; k++)
            begin
                r = rnd_req(names);
                if (r.fn == FUNC_LOAD || r.fn == FUNC_READ)
                    if ($urandom_range(0, 2) != 0)
                        r.idx = 5'($urandom_range(0, (active_n() > 0) ? active_n() - 1 : 3));
                if (r.fn == FUNC_LOAD)
                    r.nname = 8'(100 + r.idx % names);
                send(r);
            end
            drain();
        end

        $display("covered loads, hellos, routes, sweeps and reads over six register settings");
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        done = 1'b1;
        $finish;
    end

    // receiver: random stalls, one long hold-off when asked
    initial
    begin
        int hold;
        forever
        begin
            @(posedge clk);
            if (long_stall)
            begin
                long_stall = 1'b0;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            hold = gap_len();
            if (hold == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        route_rsp_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{table_changed, name_found, entry_name, entry_cost, entry_next_hop,
                    entry_adjacent, entry_connected, entry_alive};
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction %h", got);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000 && !done)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end
endmodule

>>> distance_vector_route_table.f
+incdir+sv
sv/dvrt_pkg.sv
sv/dvrt_search.sv
sv/distance_vector_route_table.sv
bench/testbench.sv
